@@ hw/rtl/kbbl_pkg.sv @@
package kbbl_pkg;

  typedef enum logic [1:0] {
    PH_SEARCH   = 2'd0,
    PH_IN_BLOCK = 2'd1,
    PH_CLOSED   = 2'd2,
    PH_OVERFLOW = 2'd3
  } scan_phase_e;

  typedef enum logic [2:0] {
    KW_IDLE = 3'd0,
    KW_C    = 3'd1,
    KW_CO   = 3'd2,
    KW_COD  = 3'd3,
    KW_CODE = 3'd4,
    KW_WAIT = 3'd5
  } kw_progress_e;

  typedef enum logic [1:0] {
    ST_FOUND        = 2'd0,
    ST_NO_BLOCK     = 2'd1,
    ST_UNTERMINATED = 2'd2,
    ST_TOO_DEEP     = 2'd3
  } scan_status_e;

  localparam int unsigned FieldBits = 16;

  localparam logic [7:0] ChLBrace    = 8'h7B;
  localparam logic [7:0] ChRBrace    = 8'h7D;
  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChUnder     = 8'h5F;
  localparam logic [7:0] ChDash      = 8'h2D;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChUpperC    = 8'h43;
  localparam logic [7:0] ChUpperO    = 8'h4F;
  localparam logic [7:0] ChUpperD    = 8'h44;
  localparam logic [7:0] ChUpperE    = 8'h45;

  typedef struct packed {
    scan_status_e          status;
    logic [FieldBits-1:0]  block_start;
    logic [FieldBits-1:0]  block_end;
  } scan_result_t;

  function automatic logic is_ident(input logic [7:0] c);
    is_ident = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || c == ChUnder || c == ChDash;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == ChSpace) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

@@ hw/rtl/kbbl_scan.sv @@
module kbbl_scan #(
  parameter int unsigned OFFSET_BITS = 16,
  parameter int unsigned DEPTH_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            text_byte_i,
  input  logic                  last_byte_i,
  output kbbl_pkg::scan_result_t result_o
);
  import kbbl_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OffsetMax = {OFFSET_BITS{1'b1}};
  localparam logic [DEPTH_BITS-1:0]  DepthMax  = {DEPTH_BITS{1'b1}};

  scan_phase_e             phase_q, phase_d;
  kw_progress_e            kw_q, kw_d;
  logic                    comment_q, comment_d;
  logic                    string_q, string_d;
  logic                    escape_q, escape_d;
  logic                    prev_ident_q, prev_ident_d;
  logic                    overflow_q, overflow_d;
  logic [OFFSET_BITS-1:0]  offset_q, offset_d;
  logic [OFFSET_BITS-1:0]  start_q, start_d;
  logic [OFFSET_BITS-1:0]  end_q, end_d;
  logic [DEPTH_BITS-1:0]   depth_q, depth_d;

  logic                    ident, space, do_plain, do_open, kw_hit;
  logic [7:0]              kw_expect;
  logic [OFFSET_BITS-1:0]  offset_inc;
  logic [DEPTH_BITS-1:0]   depth_dec;
  logic [31:0]             start_ext, end_ext;

  assign ident      = is_ident(text_byte_i);
  assign space      = is_space(text_byte_i);
  assign offset_inc = (offset_q == OffsetMax) ? offset_q : offset_q + OFFSET_BITS'(1);
  assign depth_dec  = (depth_q != '0) ? depth_q - DEPTH_BITS'(1) : depth_q;

  always_comb begin
    unique case (kw_q)
      KW_C:    kw_expect = ChUpperO;
      KW_CO:   kw_expect = ChUpperD;
      default: kw_expect = ChUpperE;
    endcase
  end

  assign kw_hit = (text_byte_i == kw_expect);

  // next state
  always_comb begin
    phase_d      = phase_q;
    kw_d         = kw_q;
    comment_d    = comment_q;
    string_d     = string_q;
    escape_d     = escape_q;
    prev_ident_d = prev_ident_q;
    overflow_d   = overflow_q;
    start_d      = start_q;
    end_d        = end_q;
    depth_d      = depth_q;
    do_plain     = 1'b0;
    do_open      = 1'b0;

    unique case (phase_q)
      PH_SEARCH: begin
        unique case (kw_q)
          KW_C, KW_CO, KW_COD: begin
            if (kw_hit) begin
              kw_d = kw_progress_e'(kw_q + 3'd1);
            end else begin
              kw_d     = KW_IDLE;
              do_plain = 1'b1;
            end
          end
          KW_CODE: begin
            priority if (ident) kw_d = KW_IDLE;
            else if (text_byte_i == ChLBrace) do_open = 1'b1;
            else if (space) kw_d = KW_WAIT;
            else begin
              kw_d     = KW_IDLE;
              do_plain = 1'b1;
            end
          end
          KW_WAIT: begin
            if (text_byte_i == ChLBrace) begin
              do_open = 1'b1;
            end else if (!space) begin
              kw_d     = KW_IDLE;
              do_plain = 1'b1;
            end
          end
          default: begin
            kw_d     = KW_IDLE;
            do_plain = 1'b1;
          end
        endcase

        if (do_plain) begin
          if (comment_q) begin
            if (text_byte_i == ChNewline) comment_d = 1'b0;
          end else if (string_q) begin
            if (escape_q) escape_d = 1'b0;
            else if (text_byte_i == ChBackslash) escape_d = 1'b1;
            else if (text_byte_i == ChQuote) string_d = 1'b0;
          end else if (text_byte_i == ChQuote) begin
            string_d = 1'b1;
          end else if (text_byte_i == ChHash) begin
            comment_d = 1'b1;
          end else if (text_byte_i == ChUpperC && !prev_ident_q) begin
            kw_d = KW_C;
          end
        end

        if (do_open) begin
          phase_d  = PH_IN_BLOCK;
          start_d  = offset_inc;
          depth_d  = DEPTH_BITS'(1);
          string_d = 1'b0;
          escape_d = 1'b0;
          kw_d     = KW_IDLE;
        end

        prev_ident_d = ident;
      end
      PH_IN_BLOCK: begin
        if (string_q) begin
          if (escape_q) escape_d = 1'b0;
          else if (text_byte_i == ChBackslash) escape_d = 1'b1;
          else if (text_byte_i == ChQuote) string_d = 1'b0;
        end else if (text_byte_i == ChQuote) begin
          string_d = 1'b1;
        end else if (text_byte_i == ChLBrace) begin
          if (depth_q == DepthMax) begin
            overflow_d = 1'b1;
            phase_d    = PH_OVERFLOW;
          end else begin
            depth_d = depth_q + DEPTH_BITS'(1);
          end
        end else if (text_byte_i == ChRBrace) begin
          depth_d = depth_dec;
          if (depth_dec == '0) begin
            end_d   = offset_q;
            phase_d = PH_CLOSED;
          end
        end
      end
      default: ;
    endcase

    offset_d = offset_inc;
  end

  // result for the current beat, valid when it carries the last byte
  assign start_ext = 32'(start_d);
  assign end_ext   = 32'(end_d);

  always_comb begin
    result_o.block_start = '0;
    result_o.block_end   = '0;
    unique case (phase_d)
      PH_SEARCH: result_o.status = ST_NO_BLOCK;
      PH_CLOSED: begin
        result_o.status      = ST_FOUND;
        result_o.block_start = start_ext[FieldBits-1:0];
        result_o.block_end   = end_ext[FieldBits-1:0];
      end
      default: begin
        result_o.status      = overflow_d ? ST_TOO_DEEP : ST_UNTERMINATED;
        result_o.block_start = start_ext[FieldBits-1:0];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SEARCH;
      kw_q         <= KW_IDLE;
      comment_q    <= 1'b0;
      string_q     <= 1'b0;
      escape_q     <= 1'b0;
      prev_ident_q <= 1'b0;
      overflow_q   <= 1'b0;
      offset_q     <= '0;
      start_q      <= '0;
      end_q        <= '0;
      depth_q      <= '0;
    end else if (step_i) begin
      if (last_byte_i) begin
        // start over for the next text
        phase_q      <= PH_SEARCH;
        kw_q         <= KW_IDLE;
        comment_q    <= 1'b0;
        string_q     <= 1'b0;
        escape_q     <= 1'b0;
        prev_ident_q <= 1'b0;
        overflow_q   <= 1'b0;
        offset_q     <= '0;
        start_q      <= '0;
        end_q        <= '0;
        depth_q      <= '0;
      end else begin
        phase_q      <= phase_d;
        kw_q         <= kw_d;
        comment_q    <= comment_d;
        string_q     <= string_d;
        escape_q     <= escape_d;
        prev_ident_q <= prev_ident_d;
        overflow_q   <= overflow_d;
        offset_q     <= offset_d;
        start_q      <= start_d;
        end_q        <= end_d;
        depth_q      <= depth_d;
      end
    end
  end

endmodule

@@ hw/rtl/kbbl_out_reg.sv @@
module kbbl_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  kbbl_pkg::scan_result_t result_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             scan_status_o,
  output logic [15:0]            block_start_o,
  output logic [15:0]            block_end_o
);
  import kbbl_pkg::*;

  logic         valid_q, valid_d;
  scan_result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (!out_stall_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= result_i;
  end

  assign out_valid_o   = valid_q;
  assign scan_status_o = res_q.status;
  assign block_start_o = res_q.block_start;
  assign block_end_o   = res_q.block_end;

endmodule

@@ hw/rtl/keyword_brace_block_locator.sv @@
// A last byte is held in the input register, then passes through the scan logic
//   into the result register, which presents the result.
// Throughput: one byte per cycle; a last byte waits only while a stalled result is held.
// Reset clears the scan state and both valid flags; after each last byte the
//   scan state returns to its reset value on its own.
module keyword_brace_block_locator #(
  parameter int unsigned OFFSET_BITS = 16,
  parameter int unsigned DEPTH_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  scan_status_o,
  output logic [15:0] block_start_o,
  output logic [15:0] block_end_o
);
  import kbbl_pkg::*;

  logic         in_valid_q, in_valid_d;
  logic [7:0]   byte_q;
  logic         last_q;
  logic         accept, advance;
  scan_result_t result;

  // a last byte may only advance when the result register can take it
  assign advance    = in_valid_q && (!last_q || !out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= text_byte_i;
      last_q <= last_byte_i;
    end
  end

  kbbl_scan #(
    .OFFSET_BITS(OFFSET_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .text_byte_i(byte_q),
    .last_byte_i(last_q),
    .result_o   (result)
  );

  kbbl_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance && last_q),
    .result_i     (result),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .scan_status_o(scan_status_o),
    .block_start_o(block_start_o),
    .block_end_o  (block_end_o)
  );

endmodule

@@ tb/block_report_checker.sv @@
module block_report_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  text_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  scan_status_i,
  input  logic [15:0] block_start_i,
  input  logic [15:0] block_end_i,
  output int          mismatches_o,
  output int          outstanding_o
);
  import kbbl_pkg::*;

  localparam logic [15:0] OffsetTop = 16'hFFFF;
  localparam logic [15:0] DepthTop  = 16'hFFFF;

  // scanner state mirrored beat by beat
  scan_phase_e   cur_phase;
  kw_progress_e  kw_state;
  logic          comment_on;
  logic          quote_on;
  logic          escaped;
  logic          last_was_ident;
  logic          depth_hit;
  logic [15:0]   cur_offset;
  logic [15:0]   open_offset;
  logic [15:0]   close_offset;
  logic [15:0]   brace_depth;

  scan_result_t  report_q[$];
  int            reports_seen;

  function automatic logic word_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == ChUnder || c == ChDash;
  endfunction

  function automatic logic blank_char(input logic [7:0] c);
    return c == ChSpace || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == OffsetTop) ? v : v + 16'd1;
  endfunction

  task automatic clear_scan();
    cur_phase      = PH_SEARCH;
    kw_state       = KW_IDLE;
    comment_on     = 1'b0;
    quote_on       = 1'b0;
    escaped        = 1'b0;
    last_was_ident = 1'b0;
    depth_hit      = 1'b0;
    cur_offset     = '0;
    open_offset    = '0;
    close_offset   = '0;
    brace_depth    = '0;
  endtask

  // string body: an escape swallows the next byte, a quote closes
  task automatic string_char(input logic [7:0] c);
    if (escaped) escaped = 1'b0;
    else if (c == ChBackslash) escaped = 1'b1;
    else if (c == ChQuote) quote_on = 1'b0;
  endtask

  task automatic plain_char(input logic [7:0] c);
    if (comment_on) begin
      if (c == ChNewline) comment_on = 1'b0;
    end else if (quote_on) begin
      string_char(c);
    end else if (c == ChQuote) begin
      quote_on = 1'b1;
    end else if (c == ChHash) begin
      comment_on = 1'b1;
    end else if (c == ChUpperC && !last_was_ident) begin
      kw_state = KW_C;
    end
  endtask

  task automatic enter_block(input logic [15:0] at);
    cur_phase   = PH_IN_BLOCK;
    open_offset = bump(at);
    brace_depth = 16'd1;
    quote_on    = 1'b0;
    escaped     = 1'b0;
    kw_state    = KW_IDLE;
  endtask

  task automatic search_char(input logic [7:0] c, input logic [15:0] at);
    logic [7:0] want;
    want = (kw_state == KW_C) ? ChUpperO : (kw_state == KW_CO) ? ChUpperD : ChUpperE;
    case (kw_state)
      KW_C, KW_CO, KW_COD: begin
        if (c == want) kw_state = kw_progress_e'(kw_state + 3'd1);
        else begin
          kw_state = KW_IDLE;
          plain_char(c);
        end
      end
      KW_CODE: begin
        if (word_char(c)) kw_state = KW_IDLE;
        else if (c == ChLBrace) enter_block(at);
        else if (blank_char(c)) kw_state = KW_WAIT;
        else begin
          kw_state = KW_IDLE;
          plain_char(c);
        end
      end
      KW_WAIT: begin
        if (c == ChLBrace) enter_block(at);
        else if (!blank_char(c)) begin
          kw_state = KW_IDLE;
          plain_char(c);
        end
      end
      default: begin
        kw_state = KW_IDLE;
        plain_char(c);
      end
    endcase
    last_was_ident = word_char(c);
  endtask

  // inside the block: strings count, comments do not
  task automatic block_char(input logic [7:0] c, input logic [15:0] at);
    if (quote_on) begin
      string_char(c);
    end else if (c == ChQuote) begin
      quote_on = 1'b1;
    end else if (c == ChLBrace) begin
      if (brace_depth == DepthTop) begin
        depth_hit = 1'b1;
        cur_phase = PH_OVERFLOW;
      end else begin
        brace_depth = brace_depth + 16'd1;
      end
    end else if (c == ChRBrace) begin
      if (brace_depth != 0) brace_depth = brace_depth - 16'd1;
      if (brace_depth == 0) begin
        close_offset = at;
        cur_phase    = PH_CLOSED;
      end
    end
  endtask

  task automatic scan_beat(input logic [7:0] c, input logic fin);
    logic [15:0]  at;
    scan_result_t rpt;
    at = cur_offset;
    case (cur_phase)
      PH_SEARCH:   search_char(c, at);
      PH_IN_BLOCK: block_char(c, at);
      default: ;
    endcase
    cur_offset = bump(at);
    if (fin) begin
      rpt.block_start = '0;
      rpt.block_end   = '0;
      if (cur_phase == PH_SEARCH) begin
        rpt.status = ST_NO_BLOCK;
      end else if (cur_phase == PH_CLOSED) begin
        rpt.status      = ST_FOUND;
        rpt.block_start = open_offset;
        rpt.block_end   = close_offset;
      end else begin
        rpt.status      = depth_hit ? ST_TOO_DEEP : ST_UNTERMINATED;
        rpt.block_start = open_offset;
      end
      report_q.push_back(rpt);
      clear_scan();
    end
  endtask

  task automatic log_mismatch(input string msg);
    if (mismatches_o < 10) $display("MISMATCH %s", msg);
    mismatches_o++;
  endtask

  task automatic check_report();
    scan_result_t want;
    if (report_q.size() == 0) begin
      log_mismatch($sformatf("unexpected report %0d: status %0d start %0d end %0d",
                             reports_seen, scan_status_i, block_start_i, block_end_i));
    end else begin
      want = report_q.pop_front();
      if (scan_status_i !== want.status || block_start_i !== want.block_start ||
          block_end_i !== want.block_end)
        log_mismatch($sformatf({"report %0d: expected status %0d start %0d end %0d,",
                                " got status %0d start %0d end %0d"},
                               reports_seen, want.status, want.block_start, want.block_end,
                               scan_status_i, block_start_i, block_end_i));
    end
    reports_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan();
      report_q.delete();
      reports_seen  = 0;
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) scan_beat(text_byte_i, last_byte_i);
      if (out_valid_i && !out_stall_i) check_report();
      outstanding_o = report_q.size();
    end
  end

endmodule

@@ tb/keyword_brace_block_locator_tb.sv @@
module keyword_brace_block_locator_tb;
  import kbbl_pkg::*;

  localparam int RandomBytes   = 1280;
  localparam int HoldCycles    = 200;
  localparam int WatchdogLimit = 2000;
  localparam int TailCycles    = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  text_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  scan_status;
  logic [15:0] block_start;
  logic [15:0] block_end;

  int          mismatches;
  int          outstanding;

  bit          tx_gaps;
  bit          rx_gaps;
  bit          hold_req;
  bit          hold_active;
  logic [7:0]  txt_q[$];

  keyword_brace_block_locator u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .text_byte_i   (text_byte),
    .last_byte_i   (last_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .scan_status_o (scan_status),
    .block_start_o (block_start),
    .block_end_o   (block_end)
  );

  block_report_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .text_byte_i   (text_byte),
    .last_byte_i   (last_byte),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .scan_status_i (scan_status),
    .block_start_i (block_start),
    .block_end_i   (block_end),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] rnd_byte(input int lo, input int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic logic [7:0] rnd_blank();
    return $urandom_range(0, 1) ? ChSpace : rnd_byte(8'h09, 8'h0D);
  endfunction

  function automatic logic [7:0] rnd_word_char();
    case ($urandom_range(0, 4))
      0:       return rnd_byte("0", "9");
      1:       return rnd_byte("A", "Z");
      2:       return $urandom_range(0, 1) ? ChUnder : ChDash;
      default: return rnd_byte("a", "z");
    endcase
  endfunction

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) txt_q.push_back(s[i]);
  endtask

  // quoted run with escapes and braces that must not count
  task automatic add_quoted();
    txt_q.push_back(ChQuote);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 4))
        0: begin
          txt_q.push_back(ChBackslash);
          txt_q.push_back(rnd_byte(0, 255));
        end
        1:       txt_q.push_back(ChLBrace);
        2:       txt_q.push_back(ChRBrace);
        3:       txt_q.push_back(ChHash);
        default: txt_q.push_back(rnd_word_char());
      endcase
    end
    if ($urandom_range(0, 7) != 0) txt_q.push_back(ChQuote);
  endtask

  task automatic add_noise();
    case ($urandom_range(0, 5))
      0: txt_q.push_back(rnd_byte(0, 255));
      1: begin
        txt_q.push_back(ChHash);
        if ($urandom_range(0, 1)) push_str("CODE{");
        repeat ($urandom_range(0, 3)) txt_q.push_back(rnd_word_char());
        if ($urandom_range(0, 5) != 0) txt_q.push_back(ChNewline);
      end
      2: add_quoted();
      3: repeat ($urandom_range(1, 4)) txt_q.push_back(rnd_word_char());
      4: txt_q.push_back(rnd_blank());
      default: push_str("CODE");
    endcase
  endtask

  // mostly keyword-plus-block texts, the rest raw noise
  task automatic compose_text();
    int depth;
    txt_q.delete();
    repeat ($urandom_range(0, 3)) add_noise();
    if ($urandom_range(0, 9) < 8) begin
      case ($urandom_range(0, 7))
        0:       txt_q.push_back(rnd_word_char());
        1:       txt_q.push_back(ChNewline);
        default: ;
      endcase
      push_str("CODE");
      if ($urandom_range(0, 9) == 0)
        txt_q[txt_q.size() - 1 - $urandom_range(0, 3)] = rnd_byte(0, 255);
      case ($urandom_range(0, 9))
        0:       txt_q.push_back(rnd_word_char());
        1:       txt_q.push_back(";");
        default: ;
      endcase
      repeat ($urandom_range(0, 2)) txt_q.push_back(rnd_blank());
      txt_q.push_back(ChLBrace);
      depth = 1;
      repeat ($urandom_range(0, 10)) begin
        case ($urandom_range(0, 7))
          0, 1: begin
            txt_q.push_back(ChLBrace);
            depth++;
          end
          2, 3: begin
            if (depth > 1) begin
              txt_q.push_back(ChRBrace);
              depth--;
            end
          end
          4:       add_quoted();
          5:       txt_q.push_back(ChHash);
          6:       txt_q.push_back(rnd_byte(0, 255));
          default: txt_q.push_back(rnd_word_char());
        endcase
      end
      if ($urandom_range(0, 7) != 0) repeat (depth) txt_q.push_back(ChRBrace);
      repeat ($urandom_range(0, 3)) add_noise();
    end else begin
      repeat ($urandom_range(1, 24)) txt_q.push_back(rnd_byte(0, 255));
    end
    if (txt_q.size() == 0) txt_q.push_back(rnd_byte(0, 255));
  endtask

  // call at a falling edge; returns at the falling edge after the beat
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    last_byte <= fin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic ship_text();
    foreach (txt_q[i]) send_byte(txt_q[i], i == txt_q.size() - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin : result_sink
    int gap;
    out_stall   = 1'b0;
    hold_active = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        out_stall  <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_active = 1'b0;
      end
      gap = rx_gaps ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall) && !hold_req);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_n === 1'b1);
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int texts;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    text_byte = '0;
    last_byte = 1'b0;
    tx_gaps   = 1'b1;
    rx_gaps   = 1'b1;
    hold_req  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // found block with a quoted brace inside
    txt_q.delete();
    push_str("CODE\t{\"}\"}");
    ship_text();
    // lone top byte: no keyword
    txt_q.delete();
    txt_q.push_back(8'hFF);
    ship_text();
    // keyword broken before the brace
    txt_q.delete();
    push_str("CODE;{");
    ship_text();
    // block never closed
    txt_q.delete();
    push_str("CODE{{");
    ship_text();

    sent  = 0;
    texts = 0;
    while (sent < RandomBytes) begin
      if (texts % 8 == 0) begin
        tx_gaps = $urandom_range(0, 3) != 0;
        rx_gaps = $urandom_range(0, 3) != 0;
      end
      if (texts == 30) drain();
      compose_text();
      sent += txt_q.size();
      ship_text();
      texts++;
    end

    // hold the result side while one-byte texts pile up
    drain();
    tx_gaps  = 1'b0;
    hold_req = 1'b1;
    wait (hold_active);
    repeat (40) begin
      txt_q.delete();
      txt_q.push_back(rnd_byte(0, 255));
      ship_text();
    end

    drain();
    repeat (TailCycles) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/kbbl_pkg.sv
hw/rtl/kbbl_scan.sv
hw/rtl/kbbl_out_reg.sv
hw/rtl/keyword_brace_block_locator.sv
tb/block_report_checker.sv
tb/keyword_brace_block_locator_tb.sv
